FILE: rtl/tdssf_pkg.sv
// Shared constants and the digit-to-segment function for the
// three-digit seven-segment formatter. No dependencies.
package tdssf_pkg;

	localparam int unsigned FIELD_W = 16;
	localparam int unsigned SEG_W   = 8;
	localparam int unsigned READ_W  = 10;   // holds the clamped reading, 0..999

	localparam logic [READ_W-1:0] MAX_READING = 10'd999;
	localparam logic [SEG_W-1:0]  SEG_POINT   = 8'h80;
	localparam logic [SEG_W-1:0]  SEG_BLANK   = 8'h00;

	typedef logic [SEG_W-1:0] seg_t;

	// Segments A..G on bits 0..6, point off.
	function automatic seg_t digit_seg(input logic [3:0] d);
		seg_t s;
		case (d)
			4'd0: s = 8'h3F;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5B;
			4'd3: s = 8'h4F;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6D;
			4'd6: s = 8'h7D;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7F;
			4'd9: s = 8'h6F;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

endpackage

FILE: rtl/three_digit_seven_segment_formatter.sv
// Top level of the three-digit seven-segment formatter: input register,
// clamp / digit split / segment lookup, and output register.
// Depends on tdssf_pkg.

// Takes a mode bit and two 16-bit readings and returns hundreds, tens and
// units segment patterns (A..G on bits 0..6, point on bit 7). Raw mode shows
// raw_value clamped to 999 with leading zeros and the point on the hundreds
// digit (reads x.xx); otherwise conc_value clamped to 999 is shown with
// leading zeros blanked and no point. Two register stages: a reading that
// transfers in is held in the input register and, unless the output side
// stalls, moves to the output register; one reading can be taken every
// cycle while the output is not stalled. The digit split is done by
// reciprocal multiplies by constants in the single stage between registers.
module three_digit_seven_segment_formatter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          raw_mode,
	input  logic [tdssf_pkg::FIELD_W-1:0] raw_value,
	input  logic [tdssf_pkg::FIELD_W-1:0] conc_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tdssf_pkg::SEG_W-1:0]   hundreds_segments,
	output logic [tdssf_pkg::SEG_W-1:0]   tens_segments,
	output logic [tdssf_pkg::SEG_W-1:0]   units_segments
);

	logic                          valid_s1;
	logic                          mode_s1;
	logic [tdssf_pkg::FIELD_W-1:0] value_s1;
	logic                          valid_s2;
	logic                          load_s2;

	logic [tdssf_pkg::READ_W-1:0]  v;
	logic [15:0]                   h_prod;
	logic [3:0]                    h;
	logic [6:0]                    r;
	logic [14:0]                   t_prod;
	logic [3:0]                    t;
	logic [3:0]                    u;
	tdssf_pkg::seg_t               hs, ts, us;

	assign load_s2  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (!valid_s2 || out_ready)
				valid_s2 <= valid_s1;
		end
	end

	// Only the selected reading is kept.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1  <= raw_mode;
			value_s1 <= raw_mode ? raw_value : conc_value;
		end
	end

	always_comb begin
		v = (value_s1 > tdssf_pkg::FIELD_W'(tdssf_pkg::MAX_READING))
			? tdssf_pkg::MAX_READING : value_s1[tdssf_pkg::READ_W-1:0];
		// v/100 = (v*41)>>12, exact for v <= 999
		h_prod = 16'(v) * 16'd41;
		h      = h_prod[15:12];
		r      = 7'(v - 10'(h) * 10'd100);
		// r/10 = (r*205)>>11, exact for r <= 99
		t_prod = 15'(r) * 15'd205;
		t      = t_prod[14:11];
		u      = 4'(r - 7'(t) * 7'd10);

		if (mode_s1) begin
			hs = tdssf_pkg::digit_seg(h) | tdssf_pkg::SEG_POINT;
			ts = tdssf_pkg::digit_seg(t);
		end else begin
			hs = (v >= 10'd100) ? tdssf_pkg::digit_seg(h) : tdssf_pkg::SEG_BLANK;
			ts = (v >= 10'd10)  ? tdssf_pkg::digit_seg(t) : tdssf_pkg::SEG_BLANK;
		end
		us = tdssf_pkg::digit_seg(u);
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			hundreds_segments <= hs;
			tens_segments     <= ts;
			units_segments    <= us;
		end
	end

	assign out_valid = valid_s2;

endmodule

FILE: rtl/tdssf_checker.sv
// Port-level checker for the three-digit seven-segment formatter, with the
// bind that attaches it to the top level. Depends on tdssf_pkg.
module tdssf_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [tdssf_pkg::SEG_W-1:0] hundreds_segments,
	input logic [tdssf_pkg::SEG_W-1:0] tens_segments,
	input logic [tdssf_pkg::SEG_W-1:0] units_segments
);

	// Stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hundreds_segments)
			&& $stable(tens_segments) && $stable(units_segments))
		else $error("result changed while stalled");

	// Point only ever on the hundreds digit.
	a_point: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !tens_segments[7] && !units_segments[7])
		else $error("point lit outside hundreds digit");

	// With the hundreds digit blank, which only blanked mode gives, the units digit is not blank.
	a_units_shown: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hundreds_segments == tdssf_pkg::SEG_BLANK
			|-> units_segments != tdssf_pkg::SEG_BLANK)
		else $error("units digit blank");

	// Empty output register means the input side is free.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// Unstalled transfer reaches the output register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready ##1 out_ready |=> out_valid)
		else $error("result lost or late");

endmodule

bind three_digit_seven_segment_formatter tdssf_checker u_tdssf_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.hundreds_segments(hundreds_segments),
	.tens_segments    (tens_segments),
	.units_segments   (units_segments)
);
